@@ hw/rtl/eit_pkg.sv @@
// Shared widths, reset values and controller/datapath interface types for the tachometer.
`timescale 1ns / 1ps
`default_nettype none

package eit_pkg;

   localparam int STAMP_W = 32;
   localparam int SCALE_W = 24;
   localparam int WINDOW_SIZE_DEFAULT = 8;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd72000;

   typedef struct packed {
      logic take_request;
      logic update_ring;
      logic avg_shift;
      logic avg_mul_start;
      logic avg_from_mul;
      logic speed_div_start;
      logic speed_from_div;
      logic speed_clear;
      logic load_output;
   } eit_cmd_type;

   typedef struct packed {
      logic div_done;
      logic mul_done;
      logic avg_zero;
   } eit_status_type;

endpackage

`default_nettype wire

@@ hw/rtl/eit_divider.sv @@
// Restoring divider, one quotient bit per cycle over a programmable number of steps.
`timescale 1ns / 1ps
`default_nettype none

module eit_divider import eit_pkg::*; #(
   parameter int NUM_W = STAMP_W + 3
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [NUM_W-1:0]             numerator,
   input  wire logic [STAMP_W-1:0]           divisor,
   input  wire logic [$clog2(NUM_W+1)-1:0]   steps,
   output logic                              done,
   output logic [NUM_W-1:0]                  quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic                busy_ff;
   logic                done_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [NUM_W-1:0]    num_ff;
   logic [STAMP_W-1:0]  rem_ff;
   logic [STAMP_W-1:0]  divisor_ff;

   logic [STAMP_W:0]    shifted;
   logic [STAMP_W:0]    trial;
   logic                fits;

   always_comb begin
      shifted = {rem_ff, num_ff[NUM_W-1]};
      trial   = shifted - {1'b0, divisor_ff};
      fits    = (shifted >= {1'b0, divisor_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= steps;
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff     <= numerator;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? trial[STAMP_W-1:0] : shifted[STAMP_W-1:0];
         num_ff <= {num_ff[NUM_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

`default_nettype wire

@@ hw/rtl/eit_datapath.sv @@
// Datapath: interval ring, running window sum, scale register, average and speed units, results.
`timescale 1ns / 1ps
`default_nettype none

module eit_datapath import eit_pkg::*; #(
   parameter int WINDOW_SIZE = WINDOW_SIZE_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire eit_cmd_type         cmd,
   output eit_status_type           status,
   input  wire logic [STAMP_W-1:0]  req_timestamp,
   input  wire logic                csr_write_enable,
   input  wire logic [SCALE_W-1:0]  csr_write_data,
   output logic [STAMP_W-1:0]       rsp_interval,
   output logic [STAMP_W-1:0]       rsp_average_interval,
   output logic [SCALE_W-1:0]       rsp_speed_rpm,
   output logic                     rsp_speed_invalid
);

   localparam int SLOT_W  = $clog2(WINDOW_SIZE);
   localparam int TOTAL_W = STAMP_W + SLOT_W;
   localparam int CNT_W   = $clog2(SCALE_W + 1);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_SIZE - 1);

   // average = total * ceil(2^RECIP_SHIFT / WINDOW_SIZE) >> RECIP_SHIFT, one chunk per cycle
   localparam int MUL_CHUNK   = 10;
   localparam int MUL_STEPS   = (TOTAL_W + MUL_CHUNK) / MUL_CHUNK;
   localparam int RECIP_W     = MUL_STEPS * MUL_CHUNK;
   localparam int RECIP_SHIFT = TOTAL_W + SLOT_W;
   localparam int PROD_W      = TOTAL_W + RECIP_W;
   localparam int PART_W      = TOTAL_W + MUL_CHUNK;
   localparam int MCNT_W      = $clog2(MUL_STEPS + 1);
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << RECIP_SHIFT) + 64'(WINDOW_SIZE - 1)) / 64'(WINDOW_SIZE);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

   logic [STAMP_W-1:0]    ring_mem [WINDOW_SIZE];
   logic [WINDOW_SIZE-1:0] ring_valid_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic [STAMP_W-1:0]    last_stamp_ff;
   logic [TOTAL_W-1:0]    total_ff;
   logic [SCALE_W-1:0]    scale_ff;

   logic [STAMP_W-1:0]    gap_ff;
   logic [STAMP_W-1:0]    old_ff;
   logic                  old_valid_ff;
   logic [STAMP_W-1:0]    avg_ff;
   logic [SCALE_W-1:0]    speed_ff;
   logic                  invalid_ff;

   logic [STAMP_W-1:0]    interval_ff;
   logic [STAMP_W-1:0]    average_ff;
   logic [SCALE_W-1:0]    speed_out_ff;
   logic                  invalid_out_ff;

   logic [STAMP_W-1:0]    old_value;
   logic [TOTAL_W-1:0]    total_in;
   logic [SLOT_W-1:0]     slot_in;

   logic                  mul_busy_ff;
   logic                  mul_done_ff;
   logic [MCNT_W-1:0]     mul_count_ff;
   logic [RECIP_W-1:0]    recip_ff;
   logic [PROD_W-1:0]     acc_ff;
   logic [PART_W-1:0]     mul_part;
   logic [PROD_W-1:0]     acc_in;

   logic                  div_done;
   logic [SCALE_W-1:0]    div_quotient;

   always_comb begin
      old_value = old_valid_ff ? old_ff : '0;
      total_in  = total_ff - TOTAL_W'(old_value) + TOTAL_W'(gap_ff);
      slot_in   = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
   end

   always_comb begin
      mul_part = {{MUL_CHUNK{1'b0}}, total_ff}
               * {{TOTAL_W{1'b0}}, recip_ff[RECIP_W-1 -: MUL_CHUNK]};
      acc_in   = {acc_ff[PROD_W-MUL_CHUNK-1:0], {MUL_CHUNK{1'b0}}} + PROD_W'(mul_part);
   end

   eit_divider #(
      .NUM_W (SCALE_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.speed_div_start),
      .numerator (scale_ff),
      .divisor   (avg_ff),
      .steps     (CNT_W'(SCALE_W)),
      .done      (div_done),
      .quotient  (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_valid_ff <= '0;
         slot_ff       <= '0;
         last_stamp_ff <= '0;
         total_ff      <= '0;
         scale_ff      <= SCALE_RESET;
      end else begin
         if (csr_write_enable) begin
            scale_ff <= csr_write_data;
         end
         if (cmd.take_request) begin
            last_stamp_ff <= req_timestamp;
         end
         if (cmd.update_ring) begin
            ring_valid_ff[slot_ff] <= 1'b1;
            slot_ff                <= slot_in;
            total_ff               <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_request) begin
         gap_ff       <= req_timestamp - last_stamp_ff;
         old_ff       <= ring_mem[slot_ff];
         old_valid_ff <= ring_valid_ff[slot_ff];
      end
      if (cmd.update_ring) begin
         ring_mem[slot_ff] <= gap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_busy_ff  <= 1'b0;
         mul_done_ff  <= 1'b0;
         mul_count_ff <= '0;
      end else begin
         mul_done_ff <= 1'b0;
         if (cmd.avg_mul_start) begin
            mul_busy_ff  <= 1'b1;
            mul_count_ff <= MCNT_W'(MUL_STEPS);
         end else if (mul_busy_ff) begin
            mul_count_ff <= mul_count_ff - 1'b1;
            if (mul_count_ff == MCNT_W'(1)) begin
               mul_busy_ff <= 1'b0;
               mul_done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.avg_mul_start) begin
         acc_ff   <= '0;
         recip_ff <= RECIP;
      end else if (mul_busy_ff) begin
         acc_ff   <= acc_in;
         recip_ff <= {recip_ff[RECIP_W-MUL_CHUNK-1:0], {MUL_CHUNK{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.avg_shift) begin
         avg_ff <= total_ff[TOTAL_W-1:SLOT_W];
      end else if (cmd.avg_from_mul) begin
         avg_ff <= acc_ff[RECIP_SHIFT +: STAMP_W];
      end
      if (cmd.speed_clear) begin
         speed_ff   <= '0;
         invalid_ff <= 1'b1;
      end else if (cmd.speed_from_div) begin
         speed_ff   <= div_quotient;
         invalid_ff <= 1'b0;
      end
      if (cmd.load_output) begin
         interval_ff    <= gap_ff;
         average_ff     <= avg_ff;
         speed_out_ff   <= speed_ff;
         invalid_out_ff <= invalid_ff;
      end
   end

   assign status.div_done = div_done;
   assign status.mul_done = mul_done_ff;
   assign status.avg_zero = (avg_ff == '0);

   assign rsp_interval         = interval_ff;
   assign rsp_average_interval = average_ff;
   assign rsp_speed_rpm        = speed_out_ff;
   assign rsp_speed_invalid    = invalid_out_ff;

endmodule

`default_nettype wire

@@ hw/rtl/eit_ctrl.sv @@
// Controller: sequences ring update, averaging, speed division and response handoff.
`timescale 1ns / 1ps
`default_nettype none

module eit_ctrl import eit_pkg::*; #(
   parameter int WINDOW_SIZE = WINDOW_SIZE_DEFAULT
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output eit_cmd_type          cmd,
   input  wire eit_status_type  status
);

   localparam bit IS_POW2 = ((WINDOW_SIZE & (WINDOW_SIZE - 1)) == 0);

   typedef enum logic [2:0] {
      S_IDLE,
      S_UPDATE,
      S_AVG,
      S_AVG_WAIT,
      S_CHECK,
      S_SPEED_WAIT,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take_request = 1'b1;
               state_in         = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update_ring = 1'b1;
            state_in        = S_AVG;
         end
         S_AVG: begin
            if (IS_POW2) begin
               cmd.avg_shift = 1'b1;
               state_in      = S_CHECK;
            end else begin
               cmd.avg_mul_start = 1'b1;
               state_in          = S_AVG_WAIT;
            end
         end
         S_AVG_WAIT: begin
            if (status.mul_done) begin
               cmd.avg_from_mul = 1'b1;
               state_in         = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.avg_zero) begin
               cmd.speed_clear = 1'b1;
               state_in        = S_DONE;
            end else begin
               cmd.speed_div_start = 1'b1;
               state_in            = S_SPEED_WAIT;
            end
         end
         S_SPEED_WAIT: begin
            if (status.div_done) begin
               cmd.speed_from_div = 1'b1;
               state_in           = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_output = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.load_output) begin
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted but controller stayed idle");

   a_valid_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load_output |=> rsp_valid)
      else $error("response loaded without rsp_valid");

   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == S_SPEED_WAIT))
      else $error("divider finished outside its wait state");

   a_mul_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      status.mul_done |-> (state_ff == S_AVG_WAIT))
      else $error("average multiply finished outside its wait state");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/edge_interval_tachometer.sv @@
// Top level: period-averaging tachometer built from controller and datapath.
// A request passes ring update, average, speed division and output load in turn; a power-of-two
// window averages by shift, other window sizes use a chunked multiply for the average.
// A zero average skips the speed divider.
// Requests are not overlapped: the next is taken once the result is in
// the output register. Reset clears timestamp, ring, sum and handshake; speed_scale is 72000.
`timescale 1ns / 1ps
`default_nettype none

module edge_interval_tachometer import eit_pkg::*; #(
   parameter int WINDOW_SIZE = WINDOW_SIZE_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [STAMP_W-1:0]  req_timestamp,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [STAMP_W-1:0]       rsp_interval,
   output logic [STAMP_W-1:0]       rsp_average_interval,
   output logic [SCALE_W-1:0]       rsp_speed_rpm,
   output logic                     rsp_speed_invalid,
   input  wire logic                csr_write_enable,
   input  wire logic [SCALE_W-1:0]  csr_write_data
);

   eit_cmd_type    cmd;
   eit_status_type status;

   eit_ctrl #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   eit_datapath #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_timestamp        (req_timestamp),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .rsp_interval         (rsp_interval),
      .rsp_average_interval (rsp_average_interval),
      .rsp_speed_rpm        (rsp_speed_rpm),
      .rsp_speed_invalid    (rsp_speed_invalid)
   );

endmodule

`default_nettype wire
